// File: hw/rtl/cbi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbi_pkg
// Shared widths, types and helpers for the cubic B-spline interpolator.
// ----------------------------------------------------------------------------
package cbi_pkg;

  // Fraction bits of the segment ratio; 1.0 is 2**RATIO_FRAC_BITS.
  localparam int unsigned RATIO_FRAC_BITS = 16;

  // Ratio in [0, 1.0] needs one integer bit.
  localparam int unsigned RW = RATIO_FRAC_BITS + 1;
  // Weight numerators, signed, magnitude below 8.0.
  localparam int unsigned NW = RATIO_FRAC_BITS + 4;
  // Scratch width for building the weights.
  localparam int unsigned WX = RATIO_FRAC_BITS + 5;
  // Weight times point component.
  localparam int unsigned PW = NW + 32;
  // Sum of four products.
  localparam int unsigned AW = PW + 2;
  // Magnitude after the power-of-two part of the 6*S divide.
  localparam int unsigned HX = AW - RATIO_FRAC_BITS - 2;
  // Clamped magnitude fed to the divide by three; large enough to saturate.
  localparam int unsigned HW = 34;
  // Nibbles of the divide by three, split over two stages.
  localparam int unsigned HN  = (HW + 3) / 4;
  localparam int unsigned HP  = 4 * HN;
  localparam int unsigned HNA = (HN + 1) / 2;
  localparam int unsigned HNB = HN - HNA;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CLAMP   = 2'd1,
    ST_ZERO_IV = 2'd2,
    ST_SAT     = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } pts_t;

  typedef struct packed {
    logic [31:0] num;    // |query - start|
    logic [31:0] den;    // |end - start|
    logic        tzero;  // end equals start
    logic        neg;    // ratio below zero
    pts_t        pts;
  } div_in_t;

  typedef struct packed {
    logic [RW-1:0] ratio;
    status_e       status;
    pts_t          pts;
  } div_out_t;

  // One radix-16 digit of a divide by three: returns {quotient digit, remainder}.
  function automatic logic [5:0] div3_step(input logic [1:0] rem, input logic [3:0] nib);
    logic [5:0]  val;
    logic [11:0] prod;
    logic [3:0]  qd;
    logic [5:0]  back;
    val  = {rem, nib};
    // val < 48, so val*43/128 floors to val/3
    prod = 12'(val) * 12'd43;
    qd   = prod[10:7];
    back = 6'(qd) + 6'(qd) + 6'(qd);
    return {qd, 2'(val - back)};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cbi_ratio_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbi_ratio_div
// Pipelined restoring divider for the segment ratio, one quotient bit a stage,
// with clamping and the ratio status decided in the first stage.
// ----------------------------------------------------------------------------
module cbi_ratio_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  input  cbi_pkg::div_in_t  din_i,
  output logic              vld_o,
  input  logic              rdy_i,
  output cbi_pkg::div_out_t dout_o
);
  import cbi_pkg::*;

  localparam int unsigned NS = RATIO_FRAC_BITS + 1;

  logic [NS-1:0] vld_q;
  logic [NS:0]   go;
  logic [31:0]   rem_q [NS];
  logic [31:0]   den_q [NS];
  logic [RW-1:0] quo_q [NS];
  status_e       st_q  [NS];
  pts_t          pts_q [NS];

  // A stage advances when it is empty or the next one advances.
  always_comb begin
    go[NS] = rdy_i;
    for (int k = NS - 1; k >= 0; k--) begin
      go[k] = !vld_q[k] || go[k+1];
    end
  end

  assign rdy_o = go[0];

  // First stage: integer bit, clamps and status.
  logic    ge0, eq0, force0, bit0;
  status_e st0;

  always_comb begin
    ge0    = din_i.num >= din_i.den;
    eq0    = din_i.num == din_i.den;
    force0 = din_i.tzero || din_i.neg;
    bit0   = !force0 && ge0;
    if (din_i.tzero) begin
      st0 = ST_ZERO_IV;
    end else if (din_i.neg || (ge0 && !eq0)) begin
      st0 = ST_CLAMP;
    end else begin
      st0 = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (go[0]) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[0] && vld_i) begin
      rem_q[0] <= (force0 || ge0) ? 32'd0 : din_i.num;
      // Zero interval: keep the later steps from dividing by zero.
      den_q[0] <= din_i.tzero ? 32'd1 : din_i.den;
      quo_q[0] <= {{(RW-1){1'b0}}, bit0};
      st_q[0]  <= st0;
      pts_q[0] <= din_i.pts;
    end
  end

  // Fraction stages: shift, trial subtract, keep or restore.
  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [32:0] shl;
    logic [33:0] diff;
    logic        take;

    always_comb begin
      shl  = {rem_q[k-1], 1'b0};
      diff = {1'b0, shl} - {2'b00, den_q[k-1]};
      take = !diff[33];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (go[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (go[k] && vld_q[k-1]) begin
        rem_q[k] <= take ? diff[31:0] : shl[31:0];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][RW-2:0], take};
        st_q[k]  <= st_q[k-1];
        pts_q[k] <= pts_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign dout_o = '{ratio: quo_q[NS-1], status: st_q[NS-1], pts: pts_q[NS-1]};

endmodule
`default_nettype wire

// File: hw/rtl/cubic_bspline_interpolator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bspline_interpolator_unit
// Uniform cubic B-spline evaluation of one point component per transaction.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------
//  in       sink       in_valid_i / in_stall_o   query/seg_start/seg_end, point_a..d
//  out      source     out_valid_o / out_stall_i interp_value_o, status_o
//
//  One transaction per cycle sustained while out_stall_i is low; the pipeline is
//  the one-bit-per-stage ratio divider plus two front stages and ten stages
//  of powers, weights, products and rounding.
//  Reset clears only the valid bits; the data registers are not reset.
//  Stalls ripple back stage by stage, so empty stages keep filling while a
//  result waits in the output register.
//
module cubic_bspline_interpolator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        query_time_i,
  input  logic [31:0]        seg_start_time_i,
  input  logic [31:0]        seg_end_time_i,
  input  logic signed [31:0] point_a_i,
  input  logic signed [31:0] point_b_i,
  input  logic signed [31:0] point_c_i,
  input  logic signed [31:0] point_d_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] interp_value_o,
  output logic [1:0]         status_o
);
  import cbi_pkg::*;

  localparam int unsigned NB = 10;

  localparam logic [RW-1:0]          R_ONE   = RW'(64'd1 << RATIO_FRAC_BITS);
  localparam logic [2*RW-1:0]        HALF    = (2*RW)'(64'd1 << (RATIO_FRAC_BITS - 1));
  localparam logic signed [WX-1:0]   S_X     = WX'(64'd1 << RATIO_FRAC_BITS);
  localparam logic signed [AW-1:0]   THREE_S = AW'(64'd3 << RATIO_FRAC_BITS);
  localparam logic [HP-1:0]          POS_LIM = HP'(33'h0_7FFF_FFFF);
  localparam logic [HP-1:0]          NEG_LIM = HP'(33'h0_8000_0000);

  // --------------------------------------------------------------------------
  // Front: differences, magnitudes, signs
  // --------------------------------------------------------------------------
  logic [1:0]  fv_q;
  logic [2:0]  fgo;
  logic        div_rdy;

  logic [32:0] tau_q, tdur_q;
  pts_t        pts_f_q;
  div_in_t     div_in_q, div_in_d;

  assign fgo[2]     = div_rdy;
  assign fgo[1]     = !fv_q[1] || fgo[2];
  assign fgo[0]     = !fv_q[0] || fgo[1];
  assign in_stall_o = !fgo[0];

  always_comb begin
    logic [32:0] abs_tau, abs_tdur;
    abs_tau           = tau_q[32] ? (33'd0 - tau_q) : tau_q;
    abs_tdur          = tdur_q[32] ? (33'd0 - tdur_q) : tdur_q;
    div_in_d.num      = abs_tau[31:0];
    div_in_d.den      = abs_tdur[31:0];
    div_in_d.tzero    = tdur_q == 33'd0;
    div_in_d.neg      = (tau_q != 33'd0) && (tau_q[32] != tdur_q[32]);
    div_in_d.pts      = pts_f_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      if (fgo[0]) fv_q[0] <= in_valid_i;
      if (fgo[1]) fv_q[1] <= fv_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fgo[0] && in_valid_i) begin
      tau_q   <= {1'b0, query_time_i} - {1'b0, seg_start_time_i};
      tdur_q  <= {1'b0, seg_end_time_i} - {1'b0, seg_start_time_i};
      pts_f_q <= '{a: point_a_i, b: point_b_i, c: point_c_i, d: point_d_i};
    end
    if (fgo[1] && fv_q[0]) begin
      div_in_q <= div_in_d;
    end
  end

  // --------------------------------------------------------------------------
  // Ratio divider
  // --------------------------------------------------------------------------
  logic     div_vld;
  div_out_t div_out;
  logic [NB:0]   bgo;
  logic [NB-1:0] bv_q;

  cbi_ratio_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fv_q[1]),
    .rdy_o  (div_rdy),
    .din_i  (div_in_q),
    .vld_o  (div_vld),
    .rdy_i  (bgo[0]),
    .dout_o (div_out)
  );

  // --------------------------------------------------------------------------
  // Back: powers, weights, products, sum, rounding, saturation
  // --------------------------------------------------------------------------
  always_comb begin
    bgo[NB] = !out_stall_i;
    for (int k = NB - 1; k >= 0; k--) begin
      bgo[k] = !bv_q[k] || bgo[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      if (bgo[0]) bv_q[0] <= div_vld;
      for (int k = 1; k < NB; k++) begin
        if (bgo[k]) bv_q[k] <= bv_q[k-1];
      end
    end
  end

  // Stage 0: r^2
  logic [RW-1:0] r0_q, r2_0_q;
  status_e       st0_q;
  pts_t          pts0_q;
  logic [2*RW-1:0] sq_w;
  assign sq_w = (2*RW)'(div_out.ratio) * (2*RW)'(div_out.ratio) + HALF;

  // Stage 1: r^3
  logic [RW-1:0] r1_q, r2_1_q, r3_1_q;
  status_e       st1_q;
  pts_t          pts1_q;
  logic [2*RW-1:0] cu_w;
  assign cu_w = (2*RW)'(r2_0_q) * (2*RW)'(r0_q) + HALF;

  // Stage 2: weight numerators
  logic signed [NW-1:0] n0_q, n1_q, n2_q, n3_q;
  logic signed [NW-1:0] n0_d, n1_d, n2_d, n3_d;
  status_e st2_q;
  pts_t    pts2_q;

  always_comb begin
    logic signed [WX-1:0] rx, r2x, r3x;
    rx   = WX'(r1_q);
    r2x  = WX'(r2_1_q);
    r3x  = WX'(r3_1_q);
    n0_d = NW'(S_X - (rx + rx + rx) + (r2x + r2x + r2x) - r3x);
    n1_d = NW'((S_X <<< 2) - ((r2x <<< 2) + (r2x <<< 1)) + (r3x + r3x + r3x));
    n2_d = NW'(S_X + (rx + rx + rx) + (r2x + r2x + r2x) - (r3x + r3x + r3x));
    n3_d = NW'(r3x);
  end

  // Stage 3: products
  logic signed [PW-1:0] pr0_q, pr1_q, pr2_q, pr3_q;
  status_e st3_q;

  // Stage 4, 5: adder tree
  logic signed [AW-1:0] s01_q, s23_q, acc_q;
  status_e st4_q, st5_q;

  // Stage 6: magnitude plus half, rounding away from zero
  logic [AW-2:0] xm_q;
  logic          neg6_q;
  status_e       st6_q;
  logic signed [AW-1:0] xs_w;
  assign xs_w = acc_q[AW-1] ? (THREE_S - acc_q) : (acc_q + THREE_S);

  // Stage 7: divide by three, upper digits
  logic [4*HNA-1:0] qa_q;
  logic [4*HNB-1:0] hlo_q;
  logic [1:0]       rem7_q;
  logic             neg7_q;
  status_e          st7_q;
  logic [4*HNA-1:0] qa_d;
  logic [4*HNB-1:0] hlo_d;
  logic [1:0]       rem7_d;

  always_comb begin
    logic [HX-1:0] hx;
    logic [HW-1:0] hc;
    logic [HP-1:0] hp;
    logic [5:0]    step;
    logic [1:0]    rm;
    hx = xm_q[AW-2:RATIO_FRAC_BITS+1];
    // Anything this large saturates anyway; pin it to the clamp width.
    hc = (|hx[HX-1:HW]) ? {HW{1'b1}} : hx[HW-1:0];
    hp = HP'(hc);
    rm = 2'd0;
    qa_d = '0;
    for (int i = 0; i < HNA; i++) begin
      step = div3_step(rm, hp[HP-1-4*i -: 4]);
      qa_d[4*HNA-1-4*i -: 4] = step[5:2];
      rm = step[1:0];
    end
    rem7_d = rm;
    hlo_d  = hp[4*HNB-1:0];
  end

  // Stage 8: divide by three, lower digits
  logic [HP-1:0] quo8_q;
  logic          neg8_q;
  status_e       st8_q;
  logic [4*HNB-1:0] qb_d;

  always_comb begin
    logic [5:0] step;
    logic [1:0] rm;
    rm   = rem7_q;
    qb_d = '0;
    for (int i = 0; i < HNB; i++) begin
      step = div3_step(rm, hlo_q[4*HNB-1-4*i -: 4]);
      qb_d[4*HNB-1-4*i -: 4] = step[5:2];
      rm = step[1:0];
    end
  end

  // Stage 9: sign and saturation into the output register
  logic signed [31:0] val9_q, val9_d;
  status_e            st9_q, st9_d;

  always_comb begin
    val9_d = neg8_q ? (32'sd0 - $signed(quo8_q[31:0])) : $signed(quo8_q[31:0]);
    st9_d  = st8_q;
    if (!neg8_q && (quo8_q > POS_LIM)) begin
      val9_d = 32'sh7FFF_FFFF;
      st9_d  = ST_SAT;
    end else if (neg8_q && (quo8_q > NEG_LIM)) begin
      val9_d = 32'sh8000_0000;
      st9_d  = ST_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bgo[0] && div_vld) begin
      r0_q   <= div_out.ratio;
      r2_0_q <= sq_w[RATIO_FRAC_BITS +: RW];
      st0_q  <= div_out.status;
      pts0_q <= div_out.pts;
    end
    if (bgo[1] && bv_q[0]) begin
      r1_q   <= r0_q;
      r2_1_q <= r2_0_q;
      r3_1_q <= cu_w[RATIO_FRAC_BITS +: RW];
      st1_q  <= st0_q;
      pts1_q <= pts0_q;
    end
    if (bgo[2] && bv_q[1]) begin
      n0_q   <= n0_d;
      n1_q   <= n1_d;
      n2_q   <= n2_d;
      n3_q   <= n3_d;
      st2_q  <= st1_q;
      pts2_q <= pts1_q;
    end
    if (bgo[3] && bv_q[2]) begin
      pr0_q <= PW'(n0_q) * PW'(pts2_q.a);
      pr1_q <= PW'(n1_q) * PW'(pts2_q.b);
      pr2_q <= PW'(n2_q) * PW'(pts2_q.c);
      pr3_q <= PW'(n3_q) * PW'(pts2_q.d);
      st3_q <= st2_q;
    end
    if (bgo[4] && bv_q[3]) begin
      s01_q <= AW'(pr0_q) + AW'(pr1_q);
      s23_q <= AW'(pr2_q) + AW'(pr3_q);
      st4_q <= st3_q;
    end
    if (bgo[5] && bv_q[4]) begin
      acc_q <= s01_q + s23_q;
      st5_q <= st4_q;
    end
    if (bgo[6] && bv_q[5]) begin
      xm_q   <= xs_w[AW-2:0];
      neg6_q <= acc_q[AW-1];
      st6_q  <= st5_q;
    end
    if (bgo[7] && bv_q[6]) begin
      qa_q   <= qa_d;
      hlo_q  <= hlo_d;
      rem7_q <= rem7_d;
      neg7_q <= neg6_q;
      st7_q  <= st6_q;
    end
    if (bgo[8] && bv_q[7]) begin
      quo8_q <= {qa_q, qb_d};
      neg8_q <= neg7_q;
      st8_q  <= st7_q;
    end
    if (bgo[9] && bv_q[8]) begin
      val9_q <= val9_d;
      st9_q  <= st9_d;
    end
  end

  assign out_valid_o    = bv_q[NB-1];
  assign interp_value_o = val9_q;
  assign status_o       = st9_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_empty_out_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register is empty");

  a_ratio_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld |-> (div_out.ratio <= R_ONE))
    else $error("segment ratio above one");

  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_SAT)) |->
      (interp_value_o == 32'sh7FFF_FFFF || interp_value_o == 32'sh8000_0000))
    else $error("saturation status without a limit value");

  a_zero_iv_ratio : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld && (div_out.status == ST_ZERO_IV)) |-> (div_out.ratio == '0))
    else $error("zero interval produced a nonzero ratio");

endmodule
`default_nettype wire
